// File: src/zero_run_encoder_assert.svh
// Assertion macros used by the checker file of the zero-run encoder
`ifndef ZERO_RUN_ENCODER_ASSERT_SVH
`define ZERO_RUN_ENCODER_ASSERT_SVH

// Condition implies a consequence in the same cycle
`define ZRE_ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Condition implies a consequence in the following cycle
`define ZRE_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// File: src/zre_pkg.sv
// Package of the zero-run encoder: sizes, register map, controller types
`timescale 1ns / 1ps
package zre_pkg;

    // Width of the zero run counter
    localparam int RUN_BITS = 20;
    localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

    // Configuration port
    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-3:0] REG_CODE_BASE = '0;
    localparam logic [7:0] CODE_BASE_RESET = 8'd125;

    // Controller states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LOAD  = 4'b0010,
        ST_FLUSH = 4'b0100,
        ST_BYTE  = 4'b1000
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic load_run;
        logic send_code;
        logic emit_byte;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic in_zero;
        logic count_nz;
        logic held_zero;
        logic shift_done;
        logic out_free;
    } status_t;

endpackage

// File: src/zre_ctrl.sv
// Controller state machine of the zero-run encoder
`timescale 1ns / 1ps
module zre_ctrl
    import zre_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_last,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (status.in_zero)
                    begin
                        // zero is counted; if it ends the string, flush the run at once
                        state_next = in_last ? ST_LOAD : ST_IDLE;
                    end
                    else
                    begin
                        state_next = status.count_nz ? ST_LOAD : ST_BYTE;
                    end
                end
            end
            ST_LOAD:
            begin
                cmd.load_run = 1'b1;
                state_next   = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    cmd.send_code = 1'b1;
                    if (status.shift_done)
                    begin
                        state_next = status.held_zero ? ST_IDLE : ST_BYTE;
                    end
                end
            end
            ST_BYTE:
            begin
                if (status.out_free)
                begin
                    cmd.emit_byte = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/zre_datapath.sv
// Datapath of the zero-run encoder: run counter, code shifter, output register
`timescale 1ns / 1ps
module zre_datapath
    import zre_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic [7:0] code_base,
    input  cmd_t       cmd,
    output status_t    status,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic       run_overflow
);

    logic [RUN_BITS-1:0] count_reg;
    logic                sat_reg;
    logic [RUN_BITS:0]   shift_reg;
    logic                ovf_hold_reg;
    logic [7:0]          byte_reg;
    logic                last_reg;
    logic                out_valid_reg;
    logic [7:0]          out_byte_reg;
    logic                out_last_reg;
    logic                out_ovf_reg;
    logic                shift_done;

    // Only the top one bit remains after this shift
    assign shift_done = (shift_reg[RUN_BITS:2] == '0);

    // Run counter and saturation flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sat_reg   <= 1'b0;
        end
        else if (cmd.load_run)
        begin
            count_reg <= '0;
            sat_reg   <= 1'b0;
        end
        else if (cmd.capture && (in_byte == 8'd0))
        begin
            if (count_reg == RUN_MAX)
            begin
                sat_reg <= 1'b1;
            end
            else
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Held transaction and code shifter
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
        if (cmd.load_run)
        begin
            shift_reg    <= {1'b0, count_reg} + 1'b1;
            ovf_hold_reg <= sat_reg;
        end
        else if (cmd.send_code)
        begin
            shift_reg <= shift_reg >> 1;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.send_code || cmd.emit_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.send_code)
        begin
            out_byte_reg <= code_base + {7'd0, shift_reg[0]};
            out_last_reg <= shift_done && (byte_reg == 8'd0);
            out_ovf_reg  <= ovf_hold_reg;
        end
        else if (cmd.emit_byte)
        begin
            out_byte_reg <= byte_reg;
            out_last_reg <= last_reg;
            out_ovf_reg  <= 1'b0;
        end
    end

    assign status.in_zero    = (in_byte == 8'd0);
    assign status.count_nz   = (count_reg != '0);
    assign status.held_zero  = (byte_reg == 8'd0);
    assign status.shift_done = shift_done;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign out_last     = out_last_reg;
    assign run_overflow = out_ovf_reg;

endmodule

// File: src/zero_run_encoder.sv
// Top level of the zero-run encoder: register port, controller and datapath
//
// Input channel (in_valid/in_ready, in_byte, in_last) takes one byte per
// transaction; in_last marks the final byte of a string. Output channel
// (out_valid/out_ready, out_byte, out_last, run_overflow) gives encoded bytes.
// Zero bytes are counted and give nothing until a nonzero byte or the end of
// the string flushes the run as code bytes code_base+bit, LSB first.
// Register code_base sits at address 0 of the APB port (reset 125).
// A zero byte inside a string is only counted; the controller stays idle.
// A nonzero byte with no pending run passes through state BYTE into the
// output register. A flush of a run of n zeros passes through LOAD, then
// FLUSH emits floor(log2(n+1)) code bytes, one bit a cycle unless stalled.
// in_ready is high only while the controller is idle; a new byte is taken
// while the last result still waits in the output register.
// When the receiver stalls, the output register holds and the controller
// waits; nothing is dropped. Reset clears the run counter, the saturation
// flag and the output valid; code_base returns to 125.
`timescale 1ns / 1ps
module zero_run_encoder
    import zre_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              out_last,
    output logic              run_overflow,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [7:0] code_base_reg;
    cmd_t       cmd;
    status_t    status;

    // Configuration register
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_base_reg <= CODE_BASE_RESET;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr[ADDR_W-1:2] == REG_CODE_BASE))
        begin
            code_base_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[ADDR_W-1:2] == REG_CODE_BASE) ? {24'd0, code_base_reg} : 32'd0;

    zre_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (in_last),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    zre_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_byte      (in_byte),
        .in_last      (in_last),
        .code_base    (code_base_reg),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .out_last     (out_last),
        .run_overflow (run_overflow)
    );

endmodule

// File: src/zre_checker.sv
// Port-level checker of the zero-run encoder and its bind
`timescale 1ns / 1ps
`include "zero_run_encoder_assert.svh"
module zre_port_props (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] in_byte,
    input logic       in_last,
    input logic       out_valid,
    input logic       out_ready
);

    // A pending result stays offered until taken
    `ZRE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // A nonzero byte always leads to at least one output, so input closes
    `ZRE_ASSERT_NEXT(a_nonzero_busy, clk, rst_n, in_valid && in_ready && (in_byte != 8'd0),
                     !in_ready)

    // A zero inside a string only counts, so input reopens at once
    `ZRE_ASSERT_NEXT(a_zero_free, clk, rst_n,
                     in_valid && in_ready && (in_byte == 8'd0) && !in_last, in_ready)

    // A zero that ends the string starts a flush
    `ZRE_ASSERT_NEXT(a_zero_last_flush, clk, rst_n,
                     in_valid && in_ready && (in_byte == 8'd0) && in_last, !in_ready)

endmodule

bind zero_run_encoder zre_port_props u_zre_port_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready)
);
